@@ src/msas_pkg.sv @@
// Package for the minimal set antichain store: op and status codes, word and control types.
`timescale 1ns / 1ps

package msas_pkg;

  // Port field widths
  localparam int unsigned WORD_BITS    = 64;
  localparam int unsigned REMOVED_BITS = 7;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_ASK_SUB = 2'd1,
    OP_ASK_SUP = 2'd2,
    OP_DUMP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_ANSWER   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_COMPACT,
    S_DUMP
  } state_e;

  typedef struct packed {
    op_e                  op;
    logic [WORD_BITS-1:0] set_value;
  } in_word_t;

  typedef struct packed {
    status_e                 status;
    logic                    found;
    logic [REMOVED_BITS-1:0] removed_count;
    logic [WORD_BITS-1:0]    held_set;
    logic                    store_empty;
    logic                    last;
  } out_word_t;

  // Commands broadcast to every cell of the chain
  typedef struct packed {
    logic eval;     // compare operand, latch hit flags
    logic compact;  // move one step toward a gap-free prefix
    logic rotate;   // shift held sets toward cell 0, head wraps to tail
    logic append;   // write operand into the selected cell
  } cell_ctrl_t;

endpackage

@@ src/msas_cell.sv @@
// One cell of the store chain: holds one set, its compare flags and its keep mark.
`timescale 1ns / 1ps

module msas_cell import msas_pkg::*; #(
  parameter int unsigned SET_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [SET_BITS-1:0] operand_i,
  input  logic                occupied_i,
  input  logic                append_here_i,
  input  logic                is_tail_i,
  input  logic [SET_BITS-1:0] right_data_i,
  input  logic                right_keep_i,
  input  logic                left_keep_i,
  input  logic [SET_BITS-1:0] wrap_data_i,
  output logic [SET_BITS-1:0] data_o,
  output logic                keep_o,
  output logic                sub_hit_o,
  output logic                sup_hit_o
);

  logic [SET_BITS-1:0] data_q, data_d;
  logic                keep_q, keep_d;
  logic                sub_q, sub_d;
  logic                sup_q, sup_d;
  logic                held_in_op;
  logic                op_in_held;

  // Containment tests against the broadcast operand
  assign held_in_op = ((data_q & operand_i) == data_q);
  assign op_in_held = ((data_q & operand_i) == operand_i);

  // Next state of the cell
  always_comb begin
    data_d = data_q;
    keep_d = keep_q;
    sub_d  = sub_q;
    sup_d  = sup_q;
    if (ctrl_i.eval) begin
      sub_d  = occupied_i & held_in_op;
      sup_d  = occupied_i & op_in_held;
      keep_d = occupied_i & ~op_in_held;
    end
    // Gaps bubble toward the tail, kept sets move toward cell 0
    if (ctrl_i.compact) begin
      if (!keep_q) begin
        data_d = right_data_i;
        keep_d = right_keep_i;
      end else if (!left_keep_i) begin
        keep_d = 1'b0;
      end
    end
    if (ctrl_i.rotate) begin
      data_d = is_tail_i ? wrap_data_i : right_data_i;
    end
    if (ctrl_i.append && append_here_i) begin
      data_d = operand_i;
    end
  end

  // Flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b0;
      sub_q  <= 1'b0;
      sup_q  <= 1'b0;
    end else begin
      keep_q <= keep_d;
      sub_q  <= sub_d;
      sup_q  <= sup_d;
    end
  end

  // Held set, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign keep_o    = keep_q;
  assign sub_hit_o = sub_q;
  assign sup_hit_o = sup_q;

endmodule

@@ src/minimal_set_antichain_store_core.sv @@
// Top level of the minimal set antichain store: cell chain and sequencing control.
`timescale 1ns / 1ps

// The store holds up to MAX_SETS bit sets, one per cell of a chain, and keeps
// them as an antichain in insertion order. One word is taken at a time; the
// input is ready only while the block is idle. Every operation compares the
// operand in all cells at once in the eval state; the decide state then
// decides and loads the result word, except that a dump of a non-empty store
// moves on to the dump state. A query result becomes valid in the same cycle
// as the input is ready again. An add that inserts then compacts the chain: a
// kept set moves one cell toward cell 0 per cycle, but only into a gap, so a
// run of kept sets spreads out as it moves; the operand is appended once no
// gap is left. A dump rotates the chain one cell per word, one word per set.
// Output stalls hold the decide and dump states.
module minimal_set_antichain_store_core import msas_pkg::*; #(
  parameter int unsigned SET_BITS = 64,
  parameter int unsigned MAX_SETS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned CNT_BITS = $clog2(MAX_SETS + 1);

  state_e              state_q, state_d;
  op_e                 op_q;
  logic [SET_BITS-1:0] operand_q;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic [CNT_BITS-1:0] new_count_q, new_count_d;
  logic [CNT_BITS-1:0] dump_idx_q, dump_idx_d;
  logic                out_valid_q;
  out_word_t           out_q, out_d;
  logic                out_load;
  logic                out_free;
  logic                accept;

  cell_ctrl_t          ctrl;
  logic [SET_BITS-1:0] cell_data [MAX_SETS];
  logic [MAX_SETS-1:0] keep_vec;
  logic [MAX_SETS-1:0] sub_vec;
  logic [MAX_SETS-1:0] sup_vec;
  logic [CNT_BITS-1:0] supers;
  logic                any_sub;
  logic                any_sup;
  logic                compact_done;
  logic                dump_last;

  assign accept   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;

  // Cell chain
  for (genvar i = 0; i < MAX_SETS; i++) begin : g_cell
    logic [SET_BITS-1:0] right_data;
    logic                right_keep;
    logic                left_keep;

    if (i == MAX_SETS - 1) begin : g_end
      assign right_data = '0;
      assign right_keep = 1'b0;
    end else begin : g_mid
      assign right_data = cell_data[i+1];
      assign right_keep = keep_vec[i+1];
    end

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_keep = keep_vec[i-1];
    end

    msas_cell #(
      .SET_BITS(SET_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .operand_i    (operand_q),
      .occupied_i   (CNT_BITS'(i) < count_q),
      .append_here_i(CNT_BITS'(i) == new_count_q),
      .is_tail_i    (CNT_BITS'(i) == count_q - CNT_BITS'(1)),
      .right_data_i (right_data),
      .right_keep_i (right_keep),
      .left_keep_i  (left_keep),
      .wrap_data_i  (cell_data[0]),
      .data_o       (cell_data[i]),
      .keep_o       (keep_vec[i]),
      .sub_hit_o    (sub_vec[i]),
      .sup_hit_o    (sup_vec[i])
    );
  end

  // Reductions over the latched hit flags
  assign any_sub      = |sub_vec;
  assign any_sup      = |sup_vec;
  assign supers       = CNT_BITS'($countones(sup_vec));
  assign compact_done = ~|(~keep_vec[MAX_SETS-2:0] & keep_vec[MAX_SETS-1:1]);
  assign dump_last    = (dump_idx_q == count_q - CNT_BITS'(1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    new_count_d = new_count_q;
    dump_idx_d  = dump_idx_q;
    ctrl        = '0;
    out_load    = 1'b0;
    out_d       = '0;
    out_d.last  = 1'b1;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        ctrl.eval = 1'b1;
        state_d   = S_DECIDE;
      end
      S_DECIDE: begin
        if (op_q == OP_DUMP && count_q != '0) begin
          dump_idx_d = '0;
          state_d    = S_DUMP;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          case (op_q)
            OP_ADD: begin
              if (any_sub) begin
                out_d.status = ST_REJECTED;
              end else if (count_q == CNT_BITS'(MAX_SETS) && !any_sup) begin
                out_d.status = ST_FULL;
              end else begin
                out_d.status        = ST_INSERTED;
                out_d.removed_count = REMOVED_BITS'(supers);
                new_count_d         = count_q - supers;
                state_d             = S_COMPACT;
              end
            end
            OP_ASK_SUB: begin
              out_d.status = ST_ANSWER;
              out_d.found  = any_sub;
            end
            OP_ASK_SUP: begin
              out_d.status = ST_ANSWER;
              out_d.found  = any_sup;
            end
            default: begin
              // dump of an empty store
              out_d.status      = ST_ANSWER;
              out_d.store_empty = 1'b1;
            end
          endcase
        end
      end
      S_COMPACT: begin
        if (compact_done) begin
          ctrl.append = 1'b1;
          count_d     = new_count_q + CNT_BITS'(1);
          state_d     = S_IDLE;
        end else begin
          ctrl.compact = 1'b1;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_d.status   = ST_ANSWER;
          out_d.held_set = WORD_BITS'(cell_data[0]);
          out_d.last     = dump_last;
          ctrl.rotate    = 1'b1;
          dump_idx_d     = dump_idx_q + CNT_BITS'(1);
          if (dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      new_count_q <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      new_count_q <= new_count_d;
      dump_idx_q  <= dump_idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= in_word_i.op;
      operand_q <= in_word_i.set_value[SET_BITS-1:0];
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(MAX_SETS))
    else $error("held count beyond capacity");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EVAL)
    else $error("accepted word not evaluated next cycle");

  a_compact_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMPACT |-> $countones(keep_vec) == int'(new_count_q))
    else $error("compaction lost or created a kept set");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.store_empty |-> out_word_o.last)
    else $error("empty dump word not marked last");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over an untaken word");

endmodule

@@ dv/msas_antichain_checker.sv @@
// Checker for the minimal set antichain store: predicts result words and compares them.
`timescale 1ns / 1ps

module msas_antichain_checker import msas_pkg::*; #(
  parameter int unsigned SET_BITS = 64,
  parameter int unsigned MAX_SETS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_word_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam logic [WORD_BITS-1:0] OPERAND_MASK =
    {WORD_BITS{1'b1}} >> (WORD_BITS - SET_BITS);

  // Shadow copy of the store and the result words still owed by the block
  logic [WORD_BITS-1:0] held_copy [MAX_SETS];
  int unsigned          held_total;
  out_word_t            owed_words [$];

  function automatic bit covers(input logic [WORD_BITS-1:0] outer,
                                input logic [WORD_BITS-1:0] part);
    return (outer & part) == part;
  endfunction

  function automatic int unsigned field_miss(input string field, input logic [63:0] want,
                                             input logic [63:0] got);
    if (want === got) return 0;
    $display("%0t mismatch in %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
    return 1;
  endfunction

  // Work out the words one accepted input causes and update the shadow store
  task automatic apply_operation(input in_word_t w);
    logic [WORD_BITS-1:0] v;
    int unsigned          supers;
    int unsigned          keep;
    bit                   hit;
    out_word_t            r;
    v      = w.set_value & OPERAND_MASK;
    r      = '0;
    r.last = 1'b1;
    hit    = 1'b0;
    supers = 0;
    case (w.op)
      OP_ADD: begin
        for (int i = 0; i < held_total; i++) begin
          if (covers(v, held_copy[i])) hit = 1'b1;
          else if (covers(held_copy[i], v)) supers++;
        end
        if (hit) begin
          r.status = ST_REJECTED;
        end else if (held_total - supers >= MAX_SETS) begin
          r.status = ST_FULL;
        end else begin
          // drop held supersets, keep order of the rest, append the operand
          keep = 0;
          for (int i = 0; i < held_total; i++) begin
            if (!covers(held_copy[i], v)) begin
              held_copy[keep] = held_copy[i];
              keep++;
            end
          end
          held_copy[keep] = v;
          held_total      = keep + 1;
          r.status        = ST_INSERTED;
          r.removed_count = REMOVED_BITS'(supers);
        end
        owed_words = {owed_words, r};
      end
      OP_ASK_SUB, OP_ASK_SUP: begin
        for (int i = 0; i < held_total; i++) begin
          if (w.op == OP_ASK_SUB ? covers(v, held_copy[i]) : covers(held_copy[i], v))
            hit = 1'b1;
        end
        r.status = ST_ANSWER;
        r.found  = hit;
        owed_words = {owed_words, r};
      end
      OP_DUMP: begin
        r.status = ST_ANSWER;
        if (held_total == 0) begin
          r.store_empty = 1'b1;
          owed_words = {owed_words, r};
        end else begin
          for (int i = 0; i < held_total; i++) begin
            r.held_set = held_copy[i];
            r.last     = (i + 1 == held_total);
            owed_words = {owed_words, r};
          end
        end
      end
      default: ;
    endcase
  endtask

  // Output side first, so a word is always matched against older expectations
  always @(posedge clk_i or negedge rst_ni) begin : track
    out_word_t   want;
    int unsigned misses;
    if (!rst_ni) begin
      held_total = 0;
      owed_words.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      misses = 0;
      if (out_valid_i && out_ready_i) begin
        if (owed_words.size() == 0) begin
          $display("%0t mismatch: expected no word, actual status %0d held_set 0x%0h last %0d",
                   $time, out_word_i.status, out_word_i.held_set, out_word_i.last);
          misses = 1;
        end else begin
          want   = owed_words.pop_front();
          misses = field_miss("status", want.status, out_word_i.status)
                 + field_miss("found", want.found, out_word_i.found)
                 + field_miss("removed_count", want.removed_count, out_word_i.removed_count)
                 + field_miss("held_set", want.held_set, out_word_i.held_set)
                 + field_miss("store_empty", want.store_empty, out_word_i.store_empty)
                 + field_miss("last", want.last, out_word_i.last);
        end
      end
      if (in_valid_i && in_ready_i) apply_operation(in_word_i);
      fail_count_o <= fail_count_o + misses;
      pending_o    <= owed_words.size();
    end
  end

endmodule

@@ dv/tb_minimal_set_antichain_store_core.sv @@
// Testbench top for the minimal set antichain store: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_minimal_set_antichain_store_core;
  import msas_pkg::*;

  localparam int unsigned SET_BITS      = 64;
  localparam int unsigned MAX_SETS      = 64;
  localparam int unsigned FILL_BITS     = 12;   // all pairs of these bits overfill the store
  localparam int unsigned RANDOM_WORDS  = 320;
  localparam int unsigned CALM_WORDS    = 60;
  localparam int unsigned HOLD_AT       = 30;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned STALL_LIMIT   = 2000;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  bit          calm      = 1'b0;
  int unsigned fail_count;
  int unsigned pending;

  minimal_set_antichain_store_core #(
    .SET_BITS(SET_BITS),
    .MAX_SETS(MAX_SETS)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  msas_antichain_checker #(
    .SET_BITS(SET_BITS),
    .MAX_SETS(MAX_SETS)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Random set of 'want' bits taken from the positions set in 'pool'
  function automatic logic [63:0] pick_bits(input logic [63:0] pool, input int unsigned want);
    int unsigned pos [$];
    int unsigned k;
    logic [63:0] v;
    v = '0;
    for (int b = 0; b < 64; b++) if (pool[b]) pos = {pos, int'(b)};
    for (int n = 0; n < want && pos.size() > 0; n++) begin
      k = $urandom_range(pos.size() - 1);
      v[pos[k]] = 1'b1;
      pos.delete(k);
    end
    return v;
  endfunction

  // Offer one word, with an occasional gap before it, and return at its accepting edge
  task automatic offer(input op_e code, input logic [63:0] value);
    if (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= '{op: code, set_value: value};
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Result sink: random stall bursts, one long hold-off while the store is filling
  initial begin : result_sink
    int unsigned taken;
    int unsigned stall_left;
    bit          held_once;
    taken      = 0;
    stall_left = 0;
    held_once  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) taken++;
      if (!held_once && taken >= HOLD_AT) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < 25) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [63:0] pairs [$];
    logic [63:0] pool;
    logic [63:0] value;
    int unsigned left;
    int unsigned k;
    int unsigned roll;
    op_e         code;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty store, equal and superset rejects, removal, queries, dump
    offer(OP_DUMP, {$urandom, $urandom});
    offer(OP_ASK_SUB, '0);
    offer(OP_ASK_SUP, '1);
    offer(OP_ADD, 64'h1000_0000_0000_0000);
    offer(OP_ADD, 64'h1000_0000_0000_0000);
    offer(OP_ADD, 64'h3000_0000_0000_0000);
    offer(OP_ADD, 64'hC000_0000_0000_0000);
    offer(OP_ADD, 64'h2000_0000_0000_0000);
    offer(OP_ADD, 64'h8000_0000_0000_0000);
    offer(OP_ADD, '1);
    offer(OP_ADD, 64'h0FFF_FFFF_FFFF_FFFF);
    offer(OP_ASK_SUB, '1);
    offer(OP_ASK_SUB, 64'h0000_0000_0000_0FFF);
    offer(OP_ASK_SUP, '0);
    offer(OP_ASK_SUP, 64'h4000_0000_0000_0000);
    offer(OP_ASK_SUP, 64'h8000_0000_0000_0000);
    offer(OP_DUMP, '1);

    // Fill: every pair of the low bits in random order; the last few find the store full
    for (int a = 0; a < FILL_BITS; a++)
      for (int b = a + 1; b < FILL_BITS; b++) pairs = {pairs, (64'd1 << a) | (64'd1 << b)};
    while (pairs.size() > 0) begin
      k = $urandom_range(pairs.size() - 1);
      offer(OP_ADD, pairs[k]);
      pairs.delete(k);
    end
    offer(OP_DUMP, '0);
    wait_all_results();

    // Random episodes: each draws operands from a small pool of bit positions
    left = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) wait_all_results();
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      if (left == 0) begin
        pool = pick_bits('1, $urandom_range(6, 10));
        left = $urandom_range(15, 35);
      end
      left--;
      roll = $urandom_range(99);
      code = (roll < 55) ? OP_ADD : (roll < 70) ? OP_ASK_SUB :
             (roll < 85) ? OP_ASK_SUP : OP_DUMP;
      roll = $urandom_range(99);
      if (code == OP_DUMP || roll < 10) value = {$urandom, $urandom};
      else if (roll < 15) value = pool;
      else if (roll < 18 && code != OP_ADD) value = '0;
      else value = pick_bits(pool, ($urandom_range(19) == 0) ? 1 : $urandom_range(2, 4));
      offer(code, value);
    end

    // Empty operand goes last: once held it rejects every later add
    offer(OP_DUMP, {$urandom, $urandom});
    offer(OP_ADD, '0);
    offer(OP_ADD, '0);
    offer(OP_ASK_SUB, {$urandom, $urandom});
    offer(OP_ASK_SUP, '0);
    offer(OP_DUMP, '0);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
